// ----- rtl/percent_url_decoder_macros.svh -----
// Assertion macros for the percent URL decoder.
// Used by files that assert; expects clk and rst_n in scope.
`ifndef PERCENT_URL_DECODER_MACROS_SVH
`define PERCENT_URL_DECODER_MACROS_SVH

// Same-cycle implication.
`define PUD_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PUD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pud_pkg.sv -----
// Package for the percent URL decoder: payload and state types, constants, nibble map.
// No dependencies.
`timescale 1ns / 1ps

package pud_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int OUT_LEN_BITS = 16;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'h20;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] in_char;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic                    char_valid;
        logic [7:0]              out_char;
        logic                    done_res;
        logic [OUT_LEN_BITS-1:0] decoded_length;
    } out_item_t;

    typedef struct packed {
        phase_t                 phase;
        logic [3:0]             high_nibble;
        logic [LENGTH_BITS-1:0] count;
    } dec_state_t;

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] v;
        u = c;
        if (u >= CH_LOWER_A && u <= CH_LOWER_Z)
        begin
            u = u - CASE_DELTA;
        end
        if (u <= CH_NINE)
        begin
            v = u - CH_ZERO;
        end
        else
        begin
            v = u - CH_UPPER_A + HEX_TEN;
        end
        return v[3:0];
    endfunction

endpackage

// ----- rtl/pud_step.sv -----
// One decode step: escape state machine and length counter for one input byte.
// Depends on pud_pkg.
`timescale 1ns / 1ps

module pud_step
    import pud_pkg::*;
(
    input  dec_state_t state,
    input  in_item_t   item,
    output dec_state_t state_next,
    output logic       has_result,
    output out_item_t  result
);

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

    logic                   wr;
    logic [7:0]             byte_val;
    dec_state_t             adv;
    logic [LENGTH_BITS-1:0] cnt;
    logic [31:0]            cnt_ext;

    always_comb
    begin
        wr       = 1'b0;
        byte_val = 8'h00;
        adv      = state;
        unique case (state.phase)
            PH_FIRST:
            begin
                adv.high_nibble = nibble_of(item.in_char);
                adv.phase       = PH_SECOND;
            end
            PH_SECOND:
            begin
                byte_val  = {state.high_nibble, nibble_of(item.in_char)};
                wr        = 1'b1;
                adv.phase = PH_NORMAL;
            end
            default:
            begin
                adv.phase = PH_NORMAL;
                if (item.in_char == CH_PLUS)
                begin
                    byte_val = CH_SPACE;
                    wr       = 1'b1;
                end
                else if (item.in_char == CH_PERCENT)
                begin
                    adv.phase = PH_FIRST;
                end
                else
                begin
                    byte_val = item.in_char;
                    wr       = 1'b1;
                end
            end
        endcase

        cnt = state.count;
        if (wr && cnt != COUNT_MAX)
        begin
            cnt = cnt + LENGTH_BITS'(1);
        end
        adv.count = cnt;
        cnt_ext   = 32'(cnt);

        has_result            = wr || item.last_char;
        result.char_valid     = wr;
        result.out_char       = byte_val;
        result.done_res       = item.last_char;
        result.decoded_length = (cnt_ext > 32'h0000_FFFF) ? 16'hFFFF : cnt_ext[15:0];

        if (item.last_char)
        begin
            state_next = '{phase: PH_NORMAL, high_nibble: 4'h0, count: '0};
        end
        else
        begin
            state_next = adv;
        end
    end

endmodule

// ----- rtl/percent_url_decoder.sv -----
// Top level of the percent URL decoder: input register, decode step, result register.
// Depends on pud_pkg, pud_step and percent_url_decoder_macros.svh.
//
// Form-urlencoded decoder taking one encoded byte per transfer, sustained one byte
// per clock while no result is stalled. Each byte is captured in an input register,
// decoded combinationally by the escape state machine, and its result (if any) is
// written into the result register, from which it transfers when result_stall is
// low. The rate is set by the escape phase and length counter update, which happens
// once per byte. '%' and the first escape character produce no result unless they
// are the last byte; the last byte always produces a result with done_res set and
// resets the decoder for the next string. While a result is stalled, bytes that give
// no result keep being taken, and one byte that gives a result waits in the input
// register.
`timescale 1ns / 1ps
`include "percent_url_decoder_macros.svh"

module percent_url_decoder
    import pud_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    in_item_t   s1_item_reg;
    dec_state_t state_reg;
    dec_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_item_reg;

    dec_state_t step_state;
    logic       step_has;
    out_item_t  step_result;
    logic       out_free;
    logic       s1_adv;
    logic       item_take;

    pud_step u_step (
        .state      (state_reg),
        .item       (s1_item_reg),
        .state_next (step_state),
        .has_result (step_has),
        .result     (step_result)
    );

    always_comb
    begin
        out_free       = !out_valid_reg || !result_stall;
        s1_adv         = s1_valid_reg && (out_free || !step_has);
        item_stall     = s1_valid_reg && !s1_adv;
        item_take      = item_valid && !item_stall;
        s1_valid_next  = item_take || (s1_valid_reg && !s1_adv);
        state_next     = s1_adv ? step_state : state_reg;
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = s1_adv && step_has;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_NORMAL, high_nibble: 4'h0, count: '0};
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_item_reg <= item;
        end
        if (out_free && s1_adv && step_has)
        begin
            out_item_reg <= step_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    `PUD_ASSERT_NEXT(a_reset_after_last, s1_adv && s1_item_reg.last_char,
        state_reg.phase == PH_NORMAL && state_reg.count == '0,
        "decoder state not cleared after last byte")
    `PUD_ASSERT(a_empty_only_done, result_valid && !result.char_valid,
        result.done_res, "result without byte and without done")
    `PUD_ASSERT(a_empty_zero_char, result_valid && !result.char_valid,
        result.out_char == 8'h00, "empty result carries nonzero byte")
    `PUD_ASSERT(a_stall_needs_item, item_stall, s1_valid_reg,
        "input stalled with empty input register")

endmodule
